// ===== hw/rtl/pcm_pkg.sv =====
// shared constants and controller/datapath interface structs for the prime check
// and multiplicity unit; no dependencies
package pcm_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int MULT_WIDTH  = 5;
   localparam int COUNT_WIDTH = $clog2(DATA_WIDTH + 1);
   localparam logic [MULT_WIDTH-1:0] MULT_MAX = MULT_WIDTH'(31);

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;           // capture input beat, reset divisor and count
      logic div_start;      // launch one division
      logic div_sel_val;    // 1: value / base_prime, 0: base_prime / trial divisor
      logic trial_step;     // advance trial divisor and its square
      logic val_step;       // take quotient as new value, bump count
      logic set_verdict;
      logic verdict_value;
      logic out_load;       // move verdict and count into the output register
   } pcm_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic pre_ok;         // value positive, candidate above one and not even above two
      logic sq_le_p;        // trial divisor squared does not exceed candidate
      logic div_done;
      logic rem_zero;
      logic out_free;       // output register can take a result this cycle
   } pcm_status_type;

endpackage

// ===== hw/rtl/pcm_divider.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on pcm_pkg
module pcm_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pcm_pkg::DATA_WIDTH-1:0]  dividend,
   input  logic [pcm_pkg::DATA_WIDTH-1:0]  divisor,
   output logic                            done,
   output logic [pcm_pkg::DATA_WIDTH-1:0]  quotient,
   output logic [pcm_pkg::DATA_WIDTH-1:0]  remainder
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [pcm_pkg::COUNT_WIDTH-1:0]     count_ff, count_in;
   logic [pcm_pkg::DATA_WIDTH-1:0]      quo_ff, quo_in;
   logic [pcm_pkg::DATA_WIDTH-1:0]      rem_ff, rem_in;
   logic [pcm_pkg::DATA_WIDTH-1:0]      dvs_ff, dvs_in;
   logic [pcm_pkg::DATA_WIDTH:0]        rem_shift;
   logic [pcm_pkg::DATA_WIDTH:0]        rem_diff;

   assign rem_shift = {rem_ff, quo_ff[pcm_pkg::DATA_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         if (!rem_diff[pcm_pkg::DATA_WIDTH]) begin
            rem_in = rem_diff[pcm_pkg::DATA_WIDTH-1:0];
            quo_in = {quo_ff[pcm_pkg::DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[pcm_pkg::DATA_WIDTH-1:0];
            quo_in = {quo_ff[pcm_pkg::DATA_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff + pcm_pkg::COUNT_WIDTH'(1);
         if (count_ff == pcm_pkg::COUNT_WIDTH'(pcm_pkg::DATA_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/pcm_datapath.sv =====
// datapath: input registers, trial divisor and square, shared divider, count,
// output register; depends on pcm_pkg and pcm_divider
module pcm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [pcm_pkg::DATA_WIDTH-1:0]       req_value,
   input  logic [pcm_pkg::DATA_WIDTH-1:0]       req_base_prime,
   input  pcm_pkg::pcm_cmd_type                 cmd,
   output pcm_pkg::pcm_status_type              status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid_res,
   output logic [pcm_pkg::MULT_WIDTH-1:0]       rsp_multiplicity
);

   localparam int W = pcm_pkg::DATA_WIDTH;

   logic [W-1:0]                     n_ff, n_in;
   logic [W-1:0]                     p_ff, p_in;
   logic [W-1:0]                     d_ff, d_in;
   logic [2*W-1:0]                   sq_ff, sq_in;
   logic [pcm_pkg::MULT_WIDTH-1:0]   count_ff, count_in;
   logic                             verdict_ff, verdict_in;
   logic                             out_valid_ff, out_valid_in;
   logic                             out_res_ff, out_res_in;
   logic [pcm_pkg::MULT_WIDTH-1:0]   out_mult_ff, out_mult_in;

   logic [W-1:0]                     div_dividend;
   logic [W-1:0]                     div_divisor;
   logic                             div_done;
   logic [W-1:0]                     div_quotient;
   logic [W-1:0]                     div_remainder;

   logic                             n_pos;
   logic                             p_pos;
   logic                             p_gt1;
   logic                             p_even_gt2;

   assign div_dividend = cmd.div_sel_val ? n_ff : p_ff;
   assign div_divisor  = cmd.div_sel_val ? p_ff : d_ff;

   pcm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign n_pos      = !n_ff[W-1] && (n_ff != '0);
   assign p_pos      = !p_ff[W-1] && (p_ff != '0);
   assign p_gt1      = p_ff > W'(1);
   assign p_even_gt2 = (p_ff > W'(2)) && !p_ff[0];

   always_comb begin
      n_in         = n_ff;
      p_in         = p_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      count_in     = count_ff;
      verdict_in   = verdict_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      out_mult_in  = out_mult_ff;
      if (cmd.load) begin
         n_in     = req_value;
         p_in     = req_base_prime;
         d_in     = W'(2);
         sq_in    = (2*W)'(4);
         count_in = '0;
      end
      if (cmd.trial_step) begin
         // (d+1)^2 = d^2 + 2d + 1
         d_in  = d_ff + W'(1);
         sq_in = sq_ff + {{W{1'b0}}, d_ff} + {{W{1'b0}}, d_ff} + (2*W)'(1);
      end
      if (cmd.val_step) begin
         n_in = div_quotient;
         if (count_ff != pcm_pkg::MULT_MAX) begin
            count_in = count_ff + pcm_pkg::MULT_WIDTH'(1);
         end
      end
      if (cmd.set_verdict) begin
         verdict_in = cmd.verdict_value;
      end
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_res_in   = verdict_ff;
         out_mult_in  = verdict_ff ? count_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      n_ff        <= n_in;
      p_ff        <= p_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      count_ff    <= count_in;
      verdict_ff  <= verdict_in;
      out_res_ff  <= out_res_in;
      out_mult_ff <= out_mult_in;
   end

   always_comb begin
      status.pre_ok   = n_pos && p_pos && p_gt1 && !p_even_gt2;
      status.sq_le_p  = sq_ff <= {{W{1'b0}}, p_ff};
      status.div_done = div_done;
      status.rem_zero = div_remainder == '0;
      status.out_free = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_valid_res    = out_res_ff;
   assign rsp_multiplicity = out_mult_ff;

endmodule

// ===== hw/rtl/pcm_controller.sv =====
// sequencer for trial division and valuation loops
// depends on pcm_pkg
module pcm_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pcm_pkg::pcm_status_type   status,
   output pcm_pkg::pcm_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_CHECK      = 3'd1;
   localparam logic [2:0] ST_TRIAL_TEST = 3'd2;
   localparam logic [2:0] ST_TRIAL_WAIT = 3'd3;
   localparam logic [2:0] ST_VAL_START  = 3'd4;
   localparam logic [2:0] ST_VAL_WAIT   = 3'd5;
   localparam logic [2:0] ST_FINISH     = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.pre_ok) begin
               state_in = ST_TRIAL_TEST;
            end else begin
               cmd.set_verdict   = 1'b1;
               cmd.verdict_value = 1'b0;
               state_in          = ST_FINISH;
            end
         end
         ST_TRIAL_TEST: begin
            if (status.sq_le_p) begin
               cmd.div_start = 1'b1;
               state_in      = ST_TRIAL_WAIT;
            end else begin
               // no divisor found: candidate is prime
               state_in = ST_VAL_START;
            end
         end
         ST_TRIAL_WAIT: begin
            if (status.div_done) begin
               if (status.rem_zero) begin
                  cmd.set_verdict   = 1'b1;
                  cmd.verdict_value = 1'b0;
                  state_in          = ST_FINISH;
               end else begin
                  cmd.trial_step = 1'b1;
                  state_in       = ST_TRIAL_TEST;
               end
            end
         end
         ST_VAL_START: begin
            cmd.div_start   = 1'b1;
            cmd.div_sel_val = 1'b1;
            state_in        = ST_VAL_WAIT;
         end
         ST_VAL_WAIT: begin
            cmd.div_sel_val = 1'b1;
            if (status.div_done) begin
               if (status.rem_zero) begin
                  cmd.val_step = 1'b1;
                  state_in     = ST_VAL_START;
               end else begin
                  cmd.set_verdict   = 1'b1;
                  cmd.verdict_value = 1'b1;
                  state_in          = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;

endmodule

// ===== hw/rtl/prime_check_and_multiplicity_unit.sv =====
// top level of the prime check and multiplicity unit
// depends on pcm_pkg, pcm_controller, pcm_datapath
//
//   port group  direction  contents
//   req_        in         value, base_prime (32-bit two's complement)
//   rsp_        out        valid_res, multiplicity (5 bits)
//
// one item at a time; a trivially rejected pair goes from IDLE through CHECK
// and FINISH back to IDLE; a prime candidate p runs one bit-serial division
// per trial divisor, for floor(sqrt(p)) - 1 divisors, plus one valuation
// division per factor p in the value, counting the last one that leaves a remainder
// reset is synchronous and clears the sequencer and the output valid
// a result waits in the output register while the next beat is taken;
// the unit stalls only when a second result is ready and the first is unread
module prime_check_and_multiplicity_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [pcm_pkg::DATA_WIDTH-1:0] req_value,
   input  logic signed [pcm_pkg::DATA_WIDTH-1:0] req_base_prime,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_valid_res,
   output logic [pcm_pkg::MULT_WIDTH-1:0]    rsp_multiplicity
);

   pcm_pkg::pcm_cmd_type    cmd;
   pcm_pkg::pcm_status_type status;

   pcm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .req_base_prime   (req_base_prime),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_multiplicity (rsp_multiplicity)
   );

endmodule

// ===== hw/rtl/pcm_checker.sv =====
// port-level checks for the prime check and multiplicity unit, bound to the top
// depends on pcm_pkg and prime_check_and_multiplicity_unit
module pcm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_valid_res,
   input logic [pcm_pkg::MULT_WIDTH-1:0]    rsp_multiplicity
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_valid_res)
         && $stable(rsp_multiplicity))
      else $error("stalled result beat changed");

   // invalid pair always reports zero multiplicity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_multiplicity == '0)
      else $error("invalid result with nonzero multiplicity");

   // a taken request keeps the unit busy for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous still at work");

   // a new result only appears while the sequencer is busy
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without an item at work");

endmodule

bind prime_check_and_multiplicity_unit pcm_checker u_pcm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_valid_res    (rsp_valid_res),
   .rsp_multiplicity (rsp_multiplicity)
);
